// ===== rtl/scfd_pkg.sv =====
package scfd_pkg;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;

  localparam logic [7:0] ByteU     = 8'h55;
  localparam logic [7:0] ByteN     = 8'h4E;
  localparam logic [7:0] ByteE     = 8'h45;
  localparam logic [7:0] ByteR     = 8'h52;
  localparam logic [7:0] ByteColon = 8'h3A;
  localparam logic [7:0] ByteAck   = 8'h0D;
  localparam logic [7:0] ByteNak   = 8'hDD;

  localparam logic [7:0] CmdAlive   = 8'hF0;
  localparam logic [7:0] CmdLeds    = 8'hF1;
  localparam logic [7:0] CmdBare    = 8'hF2;
  localparam logic [7:0] CmdBareAlt = 8'hA4;
  localparam logic [7:0] CmdServo   = 8'hA2;
  localparam logic [7:0] CmdSonar   = 8'hA3;
  localparam logic [7:0] CmdMotor   = 8'hA1;
  localparam logic [7:0] CmdIr      = 8'hA0;

  localparam logic [7:0] MotorSelA    = 8'd1;
  localparam logic [7:0] MotorSelB    = 8'd2;
  localparam logic [7:0] MotorSelBoth = 8'd3;

  localparam logic [11:0] ServoCentre = 12'd1500;
  localparam logic [18:0] ServoRecip  = 19'd364100;
  localparam logic [9:0]  MotorFull   = 10'd1000;

  localparam logic [3:0] ReplyHeadLen  = 4'd6;
  localparam logic [3:0] ReplyMaxWords = 4'd9;

  typedef enum logic [2:0] {
    CLS_ALIVE,
    CLS_LEDS,
    CLS_BARE,
    CLS_SERVO,
    CLS_SONAR,
    CLS_MOTOR,
    CLS_IR,
    CLS_OTHER
  } cmd_class_t;

  typedef struct packed {
    logic       release_tok;
    cmd_class_t cls;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
  } job_t;

  function automatic cmd_class_t classify(logic [7:0] code);
    cmd_class_t c;
    case (code)
      CmdAlive:            c = CLS_ALIVE;
      CmdLeds:             c = CLS_LEDS;
      CmdBare, CmdBareAlt: c = CLS_BARE;
      CmdServo:            c = CLS_SERVO;
      CmdSonar:            c = CLS_SONAR;
      CmdMotor:            c = CLS_MOTOR;
      CmdIr:               c = CLS_IR;
      default:             c = CLS_OTHER;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] reply_len(cmd_class_t cls);
    logic [3:0] n;
    case (cls)
      CLS_ALIVE: n = ReplyHeadLen + 4'd2;
      CLS_LEDS:  n = ReplyHeadLen + 4'd3;
      CLS_BARE:  n = ReplyHeadLen;
      CLS_SERVO: n = ReplyHeadLen + 4'd2;
      CLS_SONAR: n = ReplyHeadLen + 4'd1;
      CLS_MOTOR: n = ReplyHeadLen + 4'd2;
      CLS_IR:    n = ReplyHeadLen + 4'd2;
      default:   n = ReplyHeadLen + 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] reply_word(cmd_class_t cls, logic [3:0] idx,
                                            logic [15:0] led);
    logic [7:0] nb;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] w;
    nb = 8'd0;
    b0 = 8'd0;
    b1 = 8'd0;
    b2 = 8'd0;
    case (cls)
      CLS_ALIVE: begin
        nb = 8'd3; b0 = CmdAlive; b1 = ByteAck;
      end
      CLS_LEDS: begin
        nb = 8'd4; b0 = CmdLeds; b1 = led[7:0]; b2 = led[15:8];
      end
      CLS_BARE: begin
        nb = 8'd0;
      end
      CLS_SERVO: begin
        nb = 8'd3; b0 = CmdServo; b1 = ByteAck;
      end
      CLS_SONAR: begin
        nb = 8'd3; b0 = CmdSonar;
      end
      CLS_MOTOR: begin
        nb = 8'd2; b0 = CmdMotor; b1 = ByteAck;
      end
      CLS_IR: begin
        nb = 8'd3; b0 = CmdServo; b1 = ByteAck;
      end
      default: begin
        nb = 8'd2; b0 = ByteNak;
      end
    endcase
    case (idx)
      4'd0:    w = ByteU;
      4'd1:    w = ByteN;
      4'd2:    w = ByteE;
      4'd3:    w = ByteR;
      4'd4:    w = nb;
      4'd5:    w = ByteColon;
      4'd6:    w = b0;
      4'd7:    w = b1;
      4'd8:    w = b2;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/scfd_ifs.sv =====
interface scfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfd_reply_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_byte;
  logic        last_of_reply;
  logic [11:0] servo_pulse_us;
  logic [3:0]  motor_direction_pins;
  logic [9:0]  motor_a_width_us;
  logic [9:0]  motor_b_width_us;
  logic        motors_enabled;
  logic        sonar_reporting;
  logic        infrared_reporting;
  modport source (output valid, output reply_byte, output last_of_reply,
                  output servo_pulse_us, output motor_direction_pins,
                  output motor_a_width_us, output motor_b_width_us,
                  output motors_enabled, output sonar_reporting,
                  output infrared_reporting, input ready);
  modport sink (input valid, input reply_byte, input last_of_reply,
                input servo_pulse_us, input motor_direction_pins,
                input motor_a_width_us, input motor_b_width_us,
                input motors_enabled, input sonar_reporting,
                input infrared_reporting, output ready);
endinterface

interface scfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] led_status;
  modport source (output valid, output led_status, input ready);
  modport sink (input valid, input led_status, output ready);
endinterface

// ===== rtl/scfd_front.sv =====
module scfd_front
  import scfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  scfd_rx_if.sink rx,
  input  logic    queue_full,
  output logic    push,
  output job_t    push_job
);

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_GOT_U = 7'b0000010,
    PH_GOT_N = 7'b0000100,
    PH_GOT_E = 7'b0001000,
    PH_LEN   = 7'b0010000,
    PH_COLON = 7'b0100000,
    PH_PAY   = 7'b1000000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] bytes_remaining, bytes_remaining_next;
  logic [7:0] running_xor, running_xor_next;
  logic [6:0] payload_position, payload_position_next;
  logic [7:0] command_code, command_code_next;
  logic [7:0] first_argument, first_argument_next;
  logic [7:0] second_argument, second_argument_next;
  logic       release_pending;
  logic       accept;
  logic       restart;
  logic       decode;
  logic       more_payload;
  logic [7:0] b;

  assign rx.ready = !queue_full;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign more_payload = !bytes_remaining[7] && (bytes_remaining > 8'd1);

  always_comb begin
    phase_next            = phase;
    bytes_remaining_next  = bytes_remaining;
    running_xor_next      = running_xor;
    payload_position_next = payload_position;
    command_code_next     = command_code;
    first_argument_next   = first_argument;
    second_argument_next  = second_argument;
    restart               = 1'b0;
    decode                = 1'b0;
    case (phase)
      PH_GOT_U: begin
        if (b == ByteN) phase_next = PH_GOT_N;
        else restart = 1'b1;
      end
      PH_GOT_N: begin
        if (b == ByteE) phase_next = PH_GOT_E;
        else restart = 1'b1;
      end
      PH_GOT_E: begin
        if (b == ByteR) phase_next = PH_LEN;
        else restart = 1'b1;
      end
      PH_LEN: begin
        bytes_remaining_next = b;
        phase_next           = PH_COLON;
      end
      PH_COLON: begin
        if (b == ByteColon) begin
          phase_next            = PH_PAY;
          running_xor_next      = ByteU ^ ByteN ^ ByteE ^ ByteR ^ ByteColon ^ bytes_remaining;
          payload_position_next = 7'd1;
        end else begin
          restart = 1'b1;
        end
      end
      PH_PAY: begin
        bytes_remaining_next = bytes_remaining - 8'd1;
        if (more_payload) begin
          if (payload_position == 7'd1) command_code_next = b;
          else if (payload_position == 7'd2) first_argument_next = b;
          else if (payload_position == 7'd3) second_argument_next = b;
          payload_position_next = payload_position + 7'd1;
          running_xor_next      = running_xor ^ b;
        end else begin
          decode  = (running_xor == b);
          restart = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase
    if (restart) begin
      if (b == ByteU) begin
        phase_next       = PH_GOT_U;
        running_xor_next = 8'd0;
      end else begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_comb begin
    push = accept && (release_pending || decode);
    if (release_pending) begin
      push_job.release_tok = 1'b1;
      push_job.cls         = CLS_LEDS;
      push_job.arg_first   = 8'd0;
      push_job.arg_second  = 8'd0;
    end else begin
      push_job.release_tok = 1'b0;
      push_job.cls         = classify(command_code);
      push_job.arg_first   = first_argument;
      push_job.arg_second  = second_argument;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bytes_remaining  <= 8'd0;
      running_xor      <= 8'd0;
      payload_position <= 7'd0;
      command_code     <= 8'd0;
      first_argument   <= 8'd0;
      second_argument  <= 8'd0;
      release_pending  <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      bytes_remaining  <= bytes_remaining_next;
      running_xor      <= running_xor_next;
      payload_position <= payload_position_next;
      command_code     <= command_code_next;
      first_argument   <= first_argument_next;
      second_argument  <= second_argument_next;
      release_pending  <= decode && (classify(command_code) == CLS_LEDS);
    end
  end

endmodule

// ===== rtl/scfd_job_fifo.sv =====
module scfd_job_fifo
  import scfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t                slots [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCntW-1:0] count;

  assign full  = (count == FifoCntW'(FifoDepth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/scfd_back.sv =====
module scfd_back
  import scfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  job_t         head,
  input  logic         empty,
  output logic         pop,
  scfd_cfg_if.sink     cfg,
  scfd_reply_if.source reply
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_SEND = 3'b010,
    BK_HOLD = 3'b100
  } back_state_t;

  back_state_t state;
  cmd_class_t  cls;
  logic [3:0]  idx;
  logic [7:0]  sum;
  logic [15:0] led;
  logic [11:0] servo;
  logic [3:0]  dir;
  logic [9:0]  width_a;
  logic [9:0]  width_b;
  logic [2:0]  flags;

  logic        at_last;
  logic [7:0]  word;
  logic        out_accept;
  logic        ang_neg;
  logic [7:0]  ang_mag;
  logic [26:0] servo_prod;
  logic [9:0]  servo_off;
  logic [11:0] servo_new;
  logic [2:0]  flags_tog;
  logic [9:0]  vel;
  logic        rev;
  logic [3:0]  dir_base;
  logic [3:0]  dir_new;

  assign cfg.ready = 1'b1;

  assign at_last    = (idx == reply_len(cls));
  assign word       = at_last ? sum : reply_word(cls, idx, led);
  assign out_accept = reply.valid && reply.ready;
  assign pop        = (state == BK_IDLE || state == BK_HOLD) && !empty;

  always_comb begin
    reply.valid                = (state == BK_SEND);
    reply.reply_byte           = word;
    reply.last_of_reply        = at_last;
    reply.servo_pulse_us       = servo;
    reply.motor_direction_pins = dir;
    reply.motor_a_width_us     = width_a;
    reply.motor_b_width_us     = width_b;
    reply.motors_enabled       = flags[0];
    reply.sonar_reporting      = flags[1];
    reply.infrared_reporting   = flags[2];
  end

  // Angle times 1000/180, truncated towards zero, by a reciprocal multiply.
  always_comb begin
    ang_neg    = head.arg_first[7];
    ang_mag    = ang_neg ? (~head.arg_first + 8'd1) : head.arg_first;
    servo_prod = 27'(ang_mag) * 27'(ServoRecip);
    servo_off  = servo_prod[25:16];
    servo_new  = ang_neg ? (ServoCentre - 12'(servo_off)) : (ServoCentre + 12'(servo_off));
  end

  always_comb begin
    flags_tog = flags ^ 3'b001;
    vel       = flags_tog[0] ? MotorFull : 10'd0;
    rev       = (head.arg_second != 8'd0);
    dir_base  = flags_tog[0] ? dir : 4'd0;
    case (head.arg_first)
      MotorSelA:    dir_new = {dir_base[3:2], rev ? 2'b10 : 2'b01};
      MotorSelB:    dir_new = {rev ? 2'b10 : 2'b01, dir_base[1:0]};
      MotorSelBoth: dir_new = rev ? 4'b0110 : 4'b1001;
      default:      dir_new = dir_base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led <= 16'd0;
    end else if (cfg.valid && cfg.ready) begin
      led <= cfg.led_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      cls     <= CLS_OTHER;
      idx     <= 4'd0;
      sum     <= 8'd0;
      servo   <= 12'd0;
      dir     <= 4'd0;
      width_a <= 10'd0;
      width_b <= 10'd0;
      flags   <= 3'd0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (pop && !head.release_tok) begin
            cls   <= head.cls;
            idx   <= 4'd0;
            sum   <= 8'd0;
            state <= BK_SEND;
            case (head.cls)
              CLS_SERVO: servo <= servo_new;
              CLS_SONAR: flags[1] <= !flags[1];
              CLS_IR:    flags[2] <= !flags[2];
              CLS_MOTOR: begin
                flags <= flags_tog;
                dir   <= dir_new;
                if (head.arg_first inside {MotorSelA, MotorSelBoth}) width_a <= vel;
                if (head.arg_first inside {MotorSelB, MotorSelBoth}) width_b <= vel;
              end
              default: ;
            endcase
          end
        end
        BK_SEND: begin
          if (out_accept) begin
            sum <= sum ^ word;
            if (at_last) begin
              state <= BK_IDLE;
            end else begin
              idx <= idx + 4'd1;
              if (idx + 4'd1 == ReplyMaxWords) state <= BK_HOLD;
            end
          end
        end
        BK_HOLD: begin
          if (pop) state <= BK_SEND;
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/serial_command_frame_decoder.sv =====
// Frame decoder for a serial command link. One received word is taken per clock cycle
// whenever the four-entry job queue between the parser and the reply sequencer has room,
// so a steady byte stream is never stalled unless replies back up. A frame with a good
// XOR checksum queues one job, and a get-leds frame also queues a release token with the
// next accepted word. The sequencer emits the reply frame one word per cycle while the
// sink is ready, idles between frames, and updates the servo, motor and reporting fields
// as the job starts; the first word follows the queue write and the pop. The checksum word
// of a get-leds reply, its tenth, is only sent after the next received word is accepted.
module serial_command_frame_decoder
  import scfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  scfd_rx_if.sink      rx,
  scfd_reply_if.source reply,
  scfd_cfg_if.sink     cfg
);

  logic push;
  job_t push_job;
  logic queue_full;
  logic pop;
  job_t head;
  logic queue_empty;

  scfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  scfd_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .head     (head),
    .empty    (queue_empty)
  );

  scfd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (queue_empty),
    .pop   (pop),
    .cfg   (cfg),
    .reply (reply)
  );

endmodule

// ===== rtl/scfd_checker.sv =====
module scfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [11:0] servo
);

  a_reset_quiet : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Reply valid straight after reset.");

  a_reset_ready : assert property (@(posedge clk) rst |=> in_ready)
    else $error("Input not ready straight after reset.");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("Stalled reply word changed.");

  a_gap_after_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("No idle cycle after the end of a reply.");

  a_servo_between : assert property (@(posedge clk) disable iff (rst)
    !$stable(servo) |-> !$past(out_valid))
    else $error("Servo width changed in the middle of a reply.");

endmodule

bind serial_command_frame_decoder scfd_checker u_scfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (rx.ready),
  .out_valid (reply.valid),
  .out_ready (reply.ready),
  .out_byte  (reply.reply_byte),
  .out_last  (reply.last_of_reply),
  .servo     (reply.servo_pulse_us)
);
